### hdl/edist_pkg.sv
// Shared constants, codes and types of the edit distance engine.
package edist_pkg;

    localparam int MAX_LEN     = 256;
    localparam int SYMBOL_BITS = 8;
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int QA_W        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DIST_W      = 9;
    localparam int CMP_W       = CNT_W + 1;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int S_DATA_W    = 8;
    localparam int OP_W        = 2;
    localparam int M_DATA_W    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY  = 2'd0,
        OP_TARGET = 2'd1,
        OP_FINISH = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_LEVENSHTEIN = 2'd0,
        MODE_ANCHORED    = 2'd1,
        MODE_HAMMING     = 2'd2,
        MODE_SPARE       = 2'd3
    } t_mode;

    localparam logic [ADDR_W-1:0] REG_METRIC_MODE = 3'd0;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TGT  = 4'b0010,
        S_FIN  = 4'b0100,
        S_FOUT = 4'b1000
    } t_state;

endpackage

### hdl/edit_distance_engine_core.sv
// Edit distance engine: stored query, column walk per target symbol, result on finish.
// A target symbol walks the column memory, one cell per cycle, from row 0 to the query length.
// A finish also walks the column and registers its result, then waits for the previous result
// to be taken. The input is not ready meanwhile; queries and clears complete in idle.
// Synchronous active-low reset clears all counters, flags and the handshake; the memories are
// not cleared, since the first target of a pair reads the column as row indices.
module edit_distance_engine_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [edist_pkg::ADDR_W-1:0]        paddr,
    input  logic [edist_pkg::DATA_W-1:0]        pwdata,
    output logic [edist_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // symbol [7:0]
    input  logic [edist_pkg::S_DATA_W-1:0]      s_tdata,
    // operation [1:0]
    input  logic [edist_pkg::OP_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // distance [8:0], query_prefix_len [17:9], target_prefix_len [26:18],
    // not_available [27], overflow_status [29:28], zero [31:30]
    output logic [edist_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int CW = edist_pkg::CNT_W;
    localparam int DW = edist_pkg::DIST_W;
    localparam int KW = edist_pkg::CMP_W;
    localparam int SB = edist_pkg::SYMBOL_BITS;

    logic [SB-1:0]               r_q_mem [edist_pkg::MAX_LEN];
    logic [DW-1:0]               r_col_mem [edist_pkg::MAX_LEN + 1];

    edist_pkg::t_state           r_state;
    logic [1:0]                  r_mode;
    logic [CW-1:0]               r_qc;
    logic [CW-1:0]               r_tc;
    logic [DW-1:0]               r_row_best;
    logic [CW-1:0]               r_row_pos;
    logic [CW-1:0]               r_mism;
    logic [1:0]                  r_ovf;
    logic [SB-1:0]               r_sym;
    logic [CW-1:0]               r_rd_idx;
    logic                        r_issue;
    logic                        r_pv;
    logic [CW-1:0]               r_pidx;
    logic [DW-1:0]               r_col_q;
    logic [SB-1:0]               r_q_q;
    logic [DW-1:0]               r_diag;
    logic [DW-1:0]               r_left;
    logic [DW-1:0]               r_min;
    logic [CW-1:0]               r_min_qp;
    logic [DW-1:0]               r_res_dist;
    logic [CW-1:0]               r_res_qp;
    logic [CW-1:0]               r_res_tp;
    logic                        r_res_na;
    logic [1:0]                  r_res_ovf;
    logic                        r_out_valid;
    logic [edist_pkg::M_DATA_W-1:0] r_out_data;

    logic                        w_in_acc;
    logic                        w_cfg_wr;
    edist_pkg::t_op              w_op;
    logic [CW-1:0]               w_qidx;
    logic [edist_pkg::QA_W-1:0]  w_qaddr;
    logic [DW-1:0]               w_up;
    logic                        w_neq;
    logic [KW-1:0]               w_cost;
    logic [KW-1:0]               w_up1;
    logic [KW-1:0]               w_left1;
    logic [KW-1:0]               w_best;
    logic [DW-1:0]               w_j;
    logic [DW-1:0]               w_cell;
    logic                        w_last;
    logic                        w_col_we;
    logic [DW-1:0]               w_col_wd;
    logic [DW-1:0]               w_fmin;
    logic [CW-1:0]               w_fmin_qp;
    logic [DW-1:0]               w_rbest;
    logic [CW-1:0]               w_rpos;
    logic [DW-1:0]               n_dist;
    logic [CW-1:0]               n_qp;
    logic [CW-1:0]               n_tp;
    logic                        n_na;
    logic                        w_out_free;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr == edist_pkg::REG_METRIC_MODE)
                      ? {{(edist_pkg::DATA_W-2){1'b0}}, r_mode} : '0;

    assign s_tready   = (r_state == edist_pkg::S_IDLE);
    assign w_in_acc   = s_tvalid && s_tready;
    assign w_op       = edist_pkg::t_op'(s_tuser);
    assign m_tvalid   = r_out_valid;
    assign m_tdata    = r_out_data;
    assign w_out_free = !r_out_valid || m_tready;

    assign w_qidx  = r_rd_idx - CW'(1);
    assign w_qaddr = w_qidx[edist_pkg::QA_W-1:0];

    always_comb begin
        w_up     = (r_tc == '0) ? DW'(r_pidx) : r_col_q;
        w_neq    = (r_q_q != r_sym);
        w_cost   = {1'b0, r_diag} + KW'(w_neq);
        w_up1    = {1'b0, w_up} + KW'(1);
        w_left1  = {1'b0, r_left} + KW'(1);
        w_best   = w_cost;
        if (w_up1 < w_best) begin
            w_best = w_up1;
        end
        if (w_left1 < w_best) begin
            w_best = w_left1;
        end
        w_j      = DW'(r_tc) + DW'(1);
        w_cell   = (r_pidx == '0) ? w_j : w_best[DW-1:0];
        w_last   = (r_pidx == r_qc);
        w_col_we = r_pv && (r_state == edist_pkg::S_TGT);
        w_col_wd = w_cell;
    end

    always_comb begin
        w_fmin    = r_min;
        w_fmin_qp = r_min_qp;
        if (w_up < r_min) begin
            w_fmin    = w_up;
            w_fmin_qp = r_pidx;
        end
        w_rbest = DW'(r_qc);
        w_rpos  = '0;
        if (r_row_best < w_rbest) begin
            w_rbest = r_row_best;
            w_rpos  = r_row_pos;
        end
        n_dist = w_up;
        n_qp   = r_qc;
        n_tp   = r_tc;
        n_na   = 1'b0;
        unique case (r_mode)
            edist_pkg::MODE_ANCHORED: begin
                if (w_rbest < w_fmin) begin
                    n_dist = w_rbest;
                    n_tp   = w_rpos;
                end else begin
                    n_dist = w_fmin;
                    n_qp   = w_fmin_qp;
                end
            end
            edist_pkg::MODE_HAMMING: begin
                n_na   = (r_qc != r_tc);
                n_dist = n_na ? '0 : DW'(r_mism);
            end
            default: begin
                n_dist = w_up;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_col_q <= r_col_mem[r_rd_idx];
        r_q_q   <= r_q_mem[w_qaddr];
        if (w_col_we) begin
            r_col_mem[r_pidx] <= w_col_wd;
        end
        if (w_in_acc && w_op == edist_pkg::OP_QUERY && r_qc < CW'(edist_pkg::MAX_LEN)) begin
            r_q_mem[r_qc[edist_pkg::QA_W-1:0]] <= s_tdata[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= edist_pkg::S_IDLE;
            r_mode      <= edist_pkg::MODE_LEVENSHTEIN;
            r_qc        <= '0;
            r_tc        <= '0;
            r_row_best  <= '1;
            r_row_pos   <= '0;
            r_mism      <= '0;
            r_ovf       <= '0;
            r_issue     <= 1'b0;
            r_pv        <= 1'b0;
            r_rd_idx    <= '0;
            r_pidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr && paddr == edist_pkg::REG_METRIC_MODE) begin
                r_mode <= pwdata[1:0];
            end
            if (m_tready && r_state != edist_pkg::S_FOUT) begin
                r_out_valid <= 1'b0;
            end
            r_pv   <= r_issue;
            r_pidx <= r_rd_idx;
            if (r_issue) begin
                if (r_rd_idx == r_qc) begin
                    r_issue <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
            end
            unique case (r_state)
                edist_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_sym    <= s_tdata[SB-1:0];
                        r_rd_idx <= '0;
                        r_min    <= '1;
                        unique case (w_op)
                            edist_pkg::OP_QUERY: begin
                                r_tc       <= '0;
                                r_row_best <= '1;
                                r_row_pos  <= '0;
                                r_mism     <= '0;
                                if (r_qc < CW'(edist_pkg::MAX_LEN)) begin
                                    r_qc     <= r_qc + CW'(1);
                                    r_ovf[1] <= 1'b0;
                                end else begin
                                    r_ovf <= 2'b01;
                                end
                            end
                            edist_pkg::OP_TARGET: begin
                                if (r_tc >= CW'(edist_pkg::MAX_LEN)) begin
                                    r_ovf[1] <= 1'b1;
                                end else begin
                                    r_issue <= 1'b1;
                                    r_state <= edist_pkg::S_TGT;
                                end
                            end
                            edist_pkg::OP_FINISH: begin
                                r_issue <= 1'b1;
                                r_state <= edist_pkg::S_FIN;
                            end
                            edist_pkg::OP_CLEAR: begin
                                r_qc       <= '0;
                                r_ovf      <= '0;
                                r_tc       <= '0;
                                r_row_best <= '1;
                                r_row_pos  <= '0;
                                r_mism     <= '0;
                            end
                        endcase
                    end
                end
                edist_pkg::S_TGT: begin
                    if (r_pv) begin
                        r_diag <= w_up;
                        r_left <= w_cell;
                        if (r_pidx != '0 && r_pidx == r_tc + CW'(1) && w_neq) begin
                            r_mism <= r_mism + CW'(1);
                        end
                        if (w_last) begin
                            if (w_cell < r_row_best) begin
                                r_row_best <= w_cell;
                                r_row_pos  <= CW'(w_j);
                            end
                            r_tc    <= CW'(w_j);
                            r_state <= edist_pkg::S_IDLE;
                        end
                    end
                end
                edist_pkg::S_FIN: begin
                    if (r_pv) begin
                        r_min    <= w_fmin;
                        r_min_qp <= w_fmin_qp;
                        if (w_last) begin
                            r_res_dist <= n_dist;
                            r_res_qp   <= n_qp;
                            r_res_tp   <= n_tp;
                            r_res_na   <= n_na;
                            r_res_ovf  <= r_ovf;
                            r_state    <= edist_pkg::S_FOUT;
                        end
                    end
                end
                edist_pkg::S_FOUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {2'b00, r_res_ovf, r_res_na, DW'(r_res_tp),
                                        DW'(r_res_qp), r_res_dist};
                        r_tc        <= '0;
                        r_row_best  <= '1;
                        r_row_pos   <= '0;
                        r_mism      <= '0;
                        r_ovf[1]    <= 1'b0;
                        r_state     <= edist_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= edist_pkg::S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pidx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_pidx <= r_qc))
        else $error("column walk passed the end of the query");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tc <= CW'(edist_pkg::MAX_LEN)) && (r_qc <= CW'(edist_pkg::MAX_LEN)))
        else $error("string length beyond the maximum");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state == edist_pkg::S_FOUT))
        else $error("result raised outside the finish sequence");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_op == edist_pkg::OP_CLEAR) |=> (r_qc == '0 && r_ovf == 2'b00))
        else $error("clear left query state behind");
`endif

endmodule
